FILE: hw/rtl/smp_pkg.sv
// Package for the spherical Mercator projection block: field widths, fixed-point
// constants, CORDIC and log tables, and the split wide multiplier helpers.
// No dependencies; every other file of the block imports it.
package smp_pkg;

  localparam int FIELD_W    = 35;
  localparam int ITERATIONS = 32;  // steps of each CORDIC, log and exp chain

  localparam logic signed [63:0] FIELD_LIMIT = 64'sd8900000000;
  localparam logic signed [63:0] LAT_LIMIT   = 64'sd1501560832;  // 89.5 degrees, Q24
  localparam logic signed [63:0] Q_ONE       = 64'sd1 <<< 60;
  localparam logic signed [63:0] Q_TWO       = 64'sd1 <<< 61;
  localparam logic signed [63:0] LN_FLOOR    = 64'sd1 <<< 49;
  localparam logic signed [63:0] PI_Q60      = 64'sh3243F6A8885A308D;
  localparam logic signed [63:0] LN2_Q60     = 64'sh0B17217F7D1CF79B;
  localparam logic [63:0]        INT64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int          MERC_RADIUS = 6378137;
  localparam logic [63:0] RADIUS_256  = 64'(MERC_RADIUS) * 64'd256;

  // Bound on the multiples of ln 2 that are tried; a saturated northing reaches at most 7.
  localparam int K_MAX = 8;

  // Radians per degree, Q60.
  localparam logic [63:0] PI_DEG = (64'(PI_Q60) + 64'd90) / 64'd180;

  // Degrees per radian, Q56.
  localparam logic [63:0] DPR_Q56 = 64'd90 * ((64'hA2F9836E4E441529 + 64'h80) >> 8);

  // Reciprocal of the radius per metre, Q84, rounded to nearest.
  localparam logic [63:0] IR_P   = 64'd1 << 62;
  localparam logic [63:0] IR_Q   = IR_P / 64'(MERC_RADIUS);
  localparam logic [63:0] IR_REM = IR_P % 64'(MERC_RADIUS);
  localparam logic [63:0] IR_Q84 = (IR_Q << 22) +
      ((IR_REM << 22) + 64'(MERC_RADIUS / 2)) / 64'(MERC_RADIUS);

  // Metres per degree, Q36.
  localparam logic [127:0] M36_WIDE =
      (128'(MERC_RADIUS) * 128'(PI_Q60) + (128'd1 << 23)) >> 24;
  localparam logic [63:0] M36_Q36 = 64'((M36_WIDE + 128'd90) / 128'd180);

  typedef logic [3:0][63:0] pp_t;

  // Quotient of a non-negative constant by a small positive constant, by long division.
  // Only evaluated on constants while the tables are built.
  function automatic longint const_quot(input longint num, input int den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int j = 62; j >= 0; j--) begin
      rem = (rem <<< 1) | ((num >>> j) & longint'(1));
      q   = q <<< 1;
      if (rem >= longint'(den)) begin
        rem = rem - longint'(den);
        q   = q | longint'(1);
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60 as a truncated series; only evaluated on constants.
  function automatic logic signed [63:0] atan_pow2(input int i);
    longint acc;
    longint t;
    acc = 0;
    if (i == 0) begin
      acc = PI_Q60 >>> 2;
    end else begin
      for (int n = 1; n * i <= 60; n += 2) begin
        t = const_quot(longint'(1) <<< (60 - n * i), n);
        if (((n >> 1) & 1) == 0) acc = acc + t;
        else acc = acc - t;
      end
    end
    return acc;
  endfunction

  // ln(1 + 2^-i) in Q60 as a truncated series; only evaluated on constants.
  function automatic logic signed [63:0] ln1p_pow2(input int i);
    longint acc;
    longint t;
    acc = 0;
    if (i == 0) begin
      acc = LN2_Q60;
    end else begin
      for (int n = 1; n * i <= 60; n++) begin
        t = const_quot(longint'(1) <<< (60 - n * i), n);
        if ((n & 1) == 1) acc = acc + t;
        else acc = acc - t;
      end
    end
    return acc;
  endfunction

  // Four 32x32 partial products of a 64x64 unsigned multiply.
  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p[0] = 64'(a[31:0]) * 64'(b[31:0]);
    p[1] = 64'(a[31:0]) * 64'(b[63:32]);
    p[2] = 64'(a[63:32]) * 64'(b[31:0]);
    p[3] = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  // Sums the partial products, rounds half up, shifts right and clamps to the signed range.
  function automatic logic [63:0] mul_fin(input pp_t pp, input int sh);
    logic [127:0] sum;
    sum = {64'd0, pp[0]} + ({64'd0, pp[1]} << 32) + ({64'd0, pp[2]} << 32) + {pp[3], 64'd0};
    if (sh > 0) sum = sum + (128'd1 << (sh - 1));
    sum = sum >> sh;
    if (sum > 128'(INT64_MAX)) sum = 128'(INT64_MAX);
    return sum[63:0];
  endfunction

  function automatic logic signed [63:0] sat_field(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > FIELD_LIMIT) r = FIELD_LIMIT;
    else if (v < -FIELD_LIMIT) r = -FIELD_LIMIT;
    return r;
  endfunction

endpackage

FILE: hw/rtl/smp_req_if.sv
// Request channel of the projection block: direction and two coordinates.
// Depends on smp_pkg for the field width.
interface smp_req_if import smp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [FIELD_W-1:0] coord_a;
  logic signed [FIELD_W-1:0] coord_b;

  modport source(output valid, req_type, coord_a, coord_b, input ready);
  modport sink(input valid, req_type, coord_a, coord_b, output ready);
endinterface

FILE: hw/rtl/smp_res_if.sv
// Result channel of the projection block: two converted coordinates.
// Depends on smp_pkg for the field width.
interface smp_res_if import smp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] result_a;
  logic signed [FIELD_W-1:0] result_b;

  modport source(output valid, result_a, result_b, input ready);
  modport sink(input valid, result_a, result_b, output ready);
endinterface

FILE: hw/rtl/smp_core.sv
// Datapath pipeline of the projection block: split multipliers, exp, CORDIC and log chains.
// Depends on smp_pkg; one stage per register, all stages advance together on en.
module smp_core import smp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic                      in_mode,
  input  logic signed [FIELD_W-1:0] in_a,
  input  logic signed [FIELD_W-1:0] in_b,
  output logic                      out_vld,
  output logic signed [FIELD_W-1:0] out_a,
  output logic signed [FIELD_W-1:0] out_b
);

  localparam int S_PREP  = 1;
  localparam int S_PP1   = 2;
  localparam int S_FIN1  = 3;
  localparam int S_PREP2 = 4;
  localparam int S_PP2   = 5;
  localparam int S_FIN2  = 6;
  localparam int S_EXP   = 5;
  localparam int S_EPP   = S_EXP + ITERATIONS;
  localparam int S_EFIN  = S_EPP + 1;
  localparam int S_ROT   = S_EFIN + 1;
  localparam int S_NORM  = S_ROT + ITERATIONS;
  localparam int S_LN    = S_NORM + 1;
  localparam int S_LNR   = S_LN + ITERATIONS;
  localparam int S_SGN   = S_LNR + 1;
  localparam int S_PP3   = S_SGN + 1;
  localparam int S_FIN3  = S_PP3 + 1;
  localparam int S_OUT   = S_FIN3 + 1;
  localparam int NS      = S_OUT + 1;

  typedef struct packed {
    logic               mode;
    logic               na;
    logic               nb;
    logic [63:0]        xa;
    logic [63:0]        xb;
    pp_t                pa;
    pp_t                pb;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] ax;
    logic signed [63:0] ay;
    logic [3:0]         sx;
    logic [3:0]         sy;
  } item_t;

  item_t          st [NS];
  logic [NS-1:0]  vld;
  item_t          in_item;

  always_comb begin
    in_item      = '0;
    in_item.mode = in_mode;
    in_item.x    = sat_field(64'(in_a));
    in_item.y    = sat_field(64'(in_b));
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int IE = (s >= S_EXP && s < S_EXP + ITERATIONS) ? s - S_EXP + 1 : 1;
    localparam int IC = (s >= S_ROT && s < S_ROT + ITERATIONS) ? s - S_ROT : 0;
    localparam int IL = (s >= S_LN && s < S_LN + ITERATIONS) ? s - S_LN + 1 : 1;
    localparam logic signed [63:0] L_EXP = ln1p_pow2(IE);
    localparam logic signed [63:0] A_ROT = atan_pow2(IC);
    localparam logic signed [63:0] L_LN  = ln1p_pow2(IL);

    item_t cur;
    item_t nx;
    logic  vin;

    if (s == 0) begin : g_src_in
      assign cur = in_item;
      assign vin = in_vld;
    end else begin : g_src_prev
      assign cur = st[s-1];
      assign vin = vld[s-1];
    end

    always_comb begin
      logic signed [63:0] lat;
      logic signed [63:0] g;
      logic signed [63:0] w;
      logic signed [63:0] tx;
      logic signed [63:0] ty;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0]        r;
      logic [3:0]         k;
      logic [3:0]         c;
      logic               d;
      nx  = cur;
      lat = '0;
      g   = '0;
      w   = '0;
      tx  = '0;
      ty  = '0;
      dx  = '0;
      dy  = '0;
      r   = '0;
      k   = '0;
      c   = '0;
      d   = 1'b0;

      if (s == S_PREP) begin
        nx.na = cur.x < 0;
        nx.xa = (cur.x < 0) ? -cur.x : cur.x;
        lat   = cur.y;
        if (!cur.mode) begin
          if (cur.y > LAT_LIMIT) lat = LAT_LIMIT;
          else if (cur.y < -LAT_LIMIT) lat = -LAT_LIMIT;
        end
        nx.nb = lat < 0;
        nx.xb = (lat < 0) ? -lat : lat;
      end

      if (s == S_PP1) begin
        nx.pa = mul_pp(cur.xa, cur.mode ? IR_Q84 : M36_Q36);
        nx.pb = mul_pp(cur.xb, cur.mode ? IR_Q84 : PI_DEG);
      end

      if (s == S_FIN1) begin
        nx.xa = cur.mode ? mul_fin(cur.pa, 32) : mul_fin(cur.pa, 52);
        nx.xb = cur.mode ? mul_fin(cur.pb, 32) : mul_fin(cur.pb, 24);
      end

      if (s == S_PREP2) begin
        if (!cur.mode) begin
          nx.z = (PI_Q60 >>> 2) + $signed(cur.xb >> 1);
          nx.x = Q_ONE;
          nx.y = '0;
        end else begin
          // Split y/R into k whole multiples of ln 2 and a residual below ln 2.
          r = cur.xb;
          for (int m = 1; m <= K_MAX; m++) begin
            if (cur.xb >= 64'(m) * 64'(LN2_Q60)) begin
              k = 4'(m);
              r = cur.xb - 64'(m) * 64'(LN2_Q60);
            end
          end
          nx.z = $signed(r);
          nx.y = Q_ONE;
          nx.x = Q_ONE >>> k;
        end
      end

      if (s == S_PP2) begin
        nx.pa = mul_pp(cur.xa, cur.mode ? DPR_Q56 : 64'd1);
      end

      if (s == S_FIN2) begin
        nx.xa = cur.mode ? mul_fin(cur.pa, 92) : mul_fin(cur.pa, 0);
      end

      if (s >= S_EXP && s < S_EXP + ITERATIONS && cur.mode) begin
        if (cur.z >= L_EXP) begin
          nx.z = cur.z - L_EXP;
          nx.y = cur.y + (cur.y >>> IE);
        end
      end

      if (s == S_EPP && cur.mode) begin
        nx.pb = mul_pp(cur.y, cur.z);
      end

      if (s == S_EFIN && cur.mode) begin
        // First-order correction for the residual left by the exp chain.
        nx.y = cur.y + $signed(mul_fin(cur.pb, 60));
        nx.z = '0;
      end

      if (s >= S_ROT && s < S_ROT + ITERATIONS) begin
        dx = cur.y >>> IC;
        dy = cur.x >>> IC;
        d  = cur.mode ? (cur.y < 0) : (cur.z >= 0);
        if (d) begin
          nx.x = cur.x - dx;
          nx.y = cur.y + dy;
          nx.z = cur.z - A_ROT;
        end else begin
          nx.x = cur.x + dx;
          nx.y = cur.y - dy;
          nx.z = cur.z + A_ROT;
        end
      end

      if (s == S_NORM && !cur.mode) begin
        w = (cur.x < LN_FLOOR) ? LN_FLOOR : cur.x;
        c = 4'd11;
        for (int j = 49; j <= 60; j++) begin
          if (w[j]) c = 4'(60 - j);
        end
        nx.x  = w <<< c;
        nx.sx = c;
        nx.ax = '0;
        w = (cur.y < LN_FLOOR) ? LN_FLOOR : cur.y;
        c = 4'd11;
        for (int j = 49; j <= 60; j++) begin
          if (w[j]) c = 4'(60 - j);
        end
        nx.y  = w <<< c;
        nx.sy = c;
        nx.ay = '0;
      end

      if (s >= S_LN && s < S_LN + ITERATIONS && !cur.mode) begin
        tx = cur.x + (cur.x >>> IL);
        ty = cur.y + (cur.y >>> IL);
        if (tx <= Q_TWO) begin
          nx.x  = tx;
          nx.ax = cur.ax + L_LN;
        end
        if (ty <= Q_TWO) begin
          nx.y  = ty;
          nx.ay = cur.ay + L_LN;
        end
      end

      if (s == S_LNR) begin
        if (!cur.mode) begin
          nx.x = LN2_Q60 - cur.ax - ((Q_TWO - cur.x) >>> 1) -
                 $signed({60'd0, cur.sx}) * LN2_Q60;
          nx.y = LN2_Q60 - cur.ay - ((Q_TWO - cur.y) >>> 1) -
                 $signed({60'd0, cur.sy}) * LN2_Q60;
        end else begin
          nx.z = (cur.z <<< 1) - (PI_Q60 >>> 1);
        end
      end

      if (s == S_SGN) begin
        g = cur.mode ? cur.z : (cur.y - cur.x);
        if (cur.nb) g = -g;
        nx.nb = g < 0;
        nx.xb = (g < 0) ? -g : g;
      end

      if (s == S_PP3) begin
        nx.pb = mul_pp(cur.xb, cur.mode ? DPR_Q56 : RADIUS_256);
      end

      if (s == S_FIN3) begin
        nx.xb = cur.mode ? mul_fin(cur.pb, 92) : mul_fin(cur.pb, 60);
      end

      if (s == S_OUT) begin
        nx.x = sat_field(cur.na ? -$signed(cur.xa) : $signed(cur.xa));
        nx.y = sat_field(cur.nb ? -$signed(cur.xb) : $signed(cur.xb));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nx;
      end
    end
  end

  assign out_vld = vld[NS-1];
  assign out_a   = st[NS-1].x[FIELD_W-1:0];
  assign out_b   = st[NS-1].y[FIELD_W-1:0];

endmodule

FILE: hw/rtl/spherical_mercator_projection_top.sv
// Top level of the spherical Mercator projection block: request and result channels,
// pipeline advance control and the output register. Depends on smp_pkg, the two
// channel interfaces and smp_core.
//
// Usage: each request on req carries req_type (0 converts degrees of longitude and
// latitude to Mercator metres, 1 converts metres back to degrees) and two coordinates;
// each request gives exactly one result on res, in request order.
// A request is taken at a clock edge where valid and ready are both high.
// Throughput is one request per cycle unless a stalled output holds the pipeline. The
// three 32-step chains (exp, CORDIC, log) each take one register stage per step, and
// the split 64-bit multipliers take two stages each.
// The result sits in an output register; while it waits for the receiver, the pipeline
// keeps taking requests as long as empty slots ahead of the output can be squeezed out.
// Once the last stage holds a finished result behind a stalled output, the whole
// pipeline and req.ready hold until the receiver takes the waiting result.
// Synchronous reset clears all valid bits; there is no other state and no
// clearing pass, so requests are taken from the first cycle after reset.
module spherical_mercator_projection_top import smp_pkg::*; (
  input logic      clk,
  input logic      rst,
  smp_req_if.sink  req,
  smp_res_if.source res
);

  logic                      en;
  logic                      core_vld;
  logic signed [FIELD_W-1:0] core_a;
  logic signed [FIELD_W-1:0] core_b;

  // The pipeline may move whenever its last stage is empty or the output slot frees up.
  assign en        = !res.valid || res.ready || !core_vld;
  assign req.ready = en;

  smp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (req.valid),
    .in_mode (req.req_type),
    .in_a    (req.coord_a),
    .in_b    (req.coord_b),
    .out_vld (core_vld),
    .out_a   (core_a),
    .out_b   (core_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= core_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!res.valid || res.ready) begin
      res.result_a <= core_a;
      res.result_b <= core_b;
    end
  end

  a_reset_clears : assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

  a_last_loaded : assert property (@(posedge clk) disable iff (rst)
    core_vld && en |=> res.valid)
    else $error("finished result left the pipeline without reaching the output");

  a_range_a : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (64'($signed(res.result_a)) <= FIELD_LIMIT &&
                   64'($signed(res.result_a)) >= -FIELD_LIMIT))
    else $error("result_a outside the saturation limits");

  a_range_b : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (64'($signed(res.result_b)) <= FIELD_LIMIT &&
                   64'($signed(res.result_b)) >= -FIELD_LIMIT))
    else $error("result_b outside the saturation limits");

endmodule
